>>> rtl/fhsb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fhsb_pkg
// Shared types and constants of the floppy head stepper and bit stream unit.
// ----------------------------------------------------------------------------
package fhsb_pkg;

   localparam int MAX_TRACKS     = 64;
   localparam int BYTES_PER_TRK  = 8192;
   localparam int MAP_ENTRIES    = 160;
   localparam int CPB_SHIFT      = 2;     // cpu_cycles divided by four gives elapsed bits
   localparam int MAX_SYNC_BITS  = 64;

   localparam int TRK_W     = $clog2(MAX_TRACKS);
   localparam int BYTE_W    = $clog2(BYTES_PER_TRK);
   localparam int MEM_AW    = TRK_W + BYTE_W;
   localparam int MEM_DEPTH = MAX_TRACKS * BYTES_PER_TRK;
   localparam int MAP_AW    = 8;
   localparam int LEN_W     = 16;
   localparam int DIV_W     = 31;   // pointer plus elapsed bits always fits
   localparam int CNT_W     = $clog2(MAX_SYNC_BITS);
   localparam int DCNT_W    = $clog2(DIV_W);

   localparam logic [7:0] MAP_NONE   = 8'hFF;
   localparam logic [7:0] HEAD_MAX   = 8'(MAP_ENTRIES - 1);
   localparam logic [7:0] HEAD_UPLIM = 8'(MAP_ENTRIES - 2);

   typedef enum logic [2:0] {
      ACT_PHASE   = 3'd0,
      ACT_ADVANCE = 3'd1,
      ACT_READ    = 3'd2,
      ACT_WRITE   = 3'd3,
      ACT_MAP     = 3'd4,
      ACT_BYTE    = 3'd5,
      ACT_LENGTH  = 3'd6,
      ACT_HEAD    = 3'd7
   } action_type;

   typedef enum logic [0:0] {
      REG_WRITE_PROTECT = 1'b0,
      REG_DISK_LOADED   = 1'b1
   } reg_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EXEC,
      ST_LK_MAP,
      ST_LK_LEN,
      ST_LK_CHK,
      ST_DIV,
      ST_RD_ADDR,
      ST_RD_BIT,
      ST_WR_ADDR,
      ST_WR_MOD,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic [2:0]  action;
      logic [1:0]  phase;
      logic        phase_on;
      logic [31:0] cpu_cycles;
      logic [7:0]  data_byte;
      logic [7:0]  map_index;
      logic [5:0]  track_select;
      logic [12:0] byte_address;
      logic [15:0] bit_length;
      logic [7:0]  target_quarter_track;
   } req_type;

   typedef struct packed {
      logic [7:0] read_value;
      logic [7:0] current_quarter_track;
      logic       track_ready;
   } rsp_type;

   // Commands from the sequencer to the storage.
   typedef struct packed {
      logic              map_we;
      logic [MAP_AW-1:0] map_waddr;
      logic [7:0]        map_wdata;
      logic [MAP_AW-1:0] map_raddr;
      logic              len_we;
      logic [TRK_W-1:0]  len_waddr;
      logic [LEN_W-1:0]  len_wdata;
      logic [TRK_W-1:0]  len_raddr;
      logic              mem_we;
      logic [MEM_AW-1:0] mem_waddr;
      logic [7:0]        mem_wdata;
      logic [MEM_AW-1:0] mem_raddr;
   } st_cmd_type;

endpackage
`default_nettype wire

>>> rtl/fhsb_divider.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fhsb_divider
// Restoring remainder unit, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module fhsb_divider (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire logic [fhsb_pkg::DIV_W-1:0] dividend,
   input  wire logic [fhsb_pkg::LEN_W-1:0] divisor,
   output logic                           done,
   output logic [fhsb_pkg::LEN_W-1:0]     remainder
);
   import fhsb_pkg::*;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [DCNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_W-1:0]  dvd_ff, dvd_in;
   logic [LEN_W-1:0]  rem_ff, rem_in;
   logic [LEN_W:0]    shifted;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      shifted = {rem_ff, dvd_ff[DIV_W-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = DCNT_W'(DIV_W - 1);
         dvd_in  = dividend;
         rem_in  = '0;
      end else if (busy_ff) begin
         if (shifted >= {1'b0, divisor}) begin
            rem_in = LEN_W'(shifted - {1'b0, divisor});
         end else begin
            rem_in = shifted[LEN_W-1:0];
         end
         dvd_in = {dvd_ff[DIV_W-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule
`default_nettype wire

>>> rtl/fhsb_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fhsb_store
// Quarter-track map, track lengths and track byte memory.
// ----------------------------------------------------------------------------
module fhsb_store (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire fhsb_pkg::st_cmd_type       cmd,
   output logic [7:0]                      map_rdata,
   output logic [fhsb_pkg::LEN_W-1:0]      len_rdata,
   output logic [7:0]                      mem_rdata
);
   import fhsb_pkg::*;

   logic [7:0]       map_mem [MAP_ENTRIES];
   logic [LEN_W-1:0] len_mem [MAX_TRACKS];
   logic [7:0]       byte_mem [MEM_DEPTH];

   logic [MAP_ENTRIES-1:0] map_vld_ff;
   logic [MAX_TRACKS-1:0]  len_vld_ff;
   logic [7:0]             map_rd_ff;
   logic                   map_rv_ff;
   logic [LEN_W-1:0]       len_rd_ff;
   logic                   len_rv_ff;
   logic [7:0]             mem_rd_ff;

   // Map and length entries not written since reset read as MAP_NONE and zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         map_vld_ff <= '0;
         len_vld_ff <= '0;
      end else begin
         if (cmd.map_we) begin
            map_vld_ff[cmd.map_waddr] <= 1'b1;
         end
         if (cmd.len_we) begin
            len_vld_ff[cmd.len_waddr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.map_we) begin
         map_mem[cmd.map_waddr] <= cmd.map_wdata;
      end
      map_rd_ff <= map_mem[cmd.map_raddr];
      map_rv_ff <= map_vld_ff[cmd.map_raddr];
   end

   always_ff @(posedge clock) begin
      if (cmd.len_we) begin
         len_mem[cmd.len_waddr] <= cmd.len_wdata;
      end
      len_rd_ff <= len_mem[cmd.len_raddr];
      len_rv_ff <= len_vld_ff[cmd.len_raddr];
   end

   always_ff @(posedge clock) begin
      if (cmd.mem_we) begin
         byte_mem[cmd.mem_waddr] <= cmd.mem_wdata;
      end
      mem_rd_ff <= byte_mem[cmd.mem_raddr];
   end

   assign map_rdata = map_rv_ff ? map_rd_ff : MAP_NONE;
   assign len_rdata = len_rv_ff ? len_rd_ff : '0;
   assign mem_rdata = mem_rd_ff;

endmodule
`default_nettype wire

>>> rtl/floppy_head_stepper_bitstream_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// floppy_head_stepper_bitstream_unit
// Floppy head stepper and bit stream engine.
//
// A request on the req_ channel carries one action (phase, time advance,
// nibble read or write, map/byte/length load, head set). Each request gives
// exactly one response on the rsp_ channel: the nibble read, the head
// quarter-track and whether the head sits over a non-empty track.
// One request is worked on at a time; req_ready is high only when idle, so
// the next request can be taken in the cycle after the response is accepted.
// Phase, load and head actions need no remainder pass; a time advance adds
// a pass of the bit-serial remainder unit; a read takes the remainder pass
// plus one byte memory read per bit (up to 64 bits); a write takes the
// remainder pass plus a read-modify-write of eight bits in the byte memory.
// The response is held until rsp_ready; no new request is taken meanwhile.
// Reset clears the stepper state, pointer, registers and the map and length
// valid bits; no clearing pass is needed. Registers are to be written through
// the configuration port only while the block is idle; the block itself
// does not enforce this.
// ----------------------------------------------------------------------------
module floppy_head_stepper_bitstream_unit (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire fhsb_pkg::req_type req_payload,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output fhsb_pkg::rsp_type      rsp_payload,
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [2:0]        paddr,
   input  wire logic [31:0]       pwdata,
   output logic [31:0]            prdata,
   output logic                   pready
);
   import fhsb_pkg::*;

   state_type        state_ff, state_in;
   req_type          req_ff, req_in;
   logic             wp_ff, wp_in;
   logic             loaded_ff, loaded_in;
   logic [3:0]       pb_ff, pb_in;
   logic [1:0]       settled_ff, settled_in;
   logic [7:0]       head_ff, head_in;
   logic [LEN_W-1:0] ptr_ff, ptr_in;
   logic [TRK_W-1:0] trk_ff, trk_in;
   logic             trk_ok_ff, trk_ok_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic             ready_ff, ready_in;
   logic [7:0]       value_ff, value_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   st_cmd_type       cmd;
   logic [7:0]       map_rdata;
   logic [LEN_W-1:0] len_rdata;
   logic [7:0]       mem_rdata;
   logic             div_start;
   logic [DIV_W-1:0] div_dividend;
   logic             div_done;
   logic [LEN_W-1:0] div_rem;

   logic             cfg_wr;
   logic             go_op;
   logic             lk_ready;
   logic [LEN_W:0]   ptr_inc;
   logic [LEN_W-1:0] ptr_adv;
   logic [2:0]       bit_sel;
   logic             cur_bit;
   logic [7:0]       value_shift;
   logic [3:0]       pb_step;
   logic [1:0]       nxt, prv;
   logic [7:0]       wbyte;
   logic [2:0]       nib_sel;

   fhsb_store u_store (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .map_rdata (map_rdata),
      .len_rdata (len_rdata),
      .mem_rdata (mem_rdata)
   );

   fhsb_divider u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (len_ff),
      .done      (div_done),
      .remainder (div_rem)
   );

   assign cfg_wr    = psel && penable && pwrite;
   assign pready    = 1'b1;
   assign prdata    = (reg_index_type'(paddr[2]) == REG_DISK_LOADED) ?
                      {31'b0, loaded_ff} : {31'b0, wp_ff};
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_RESP);
   assign rsp_payload.read_value            = value_ff;
   assign rsp_payload.current_quarter_track = head_ff;
   assign rsp_payload.track_ready           = ready_ff;

   // Lookup result and whether the action proceeds to the bit engine.
   assign lk_ready = trk_ok_ff && (len_rdata != '0);
   always_comb begin
      go_op = 1'b0;
      if (lk_ready) begin
         case (action_type'(req_ff.action)) inside
            ACT_ADVANCE, ACT_READ: go_op = 1'b1;
            ACT_WRITE:             go_op = loaded_ff && !wp_ff;
            default:               go_op = 1'b0;
         endcase
      end
   end

   assign ptr_inc     = {1'b0, ptr_ff} + 1'b1;
   assign ptr_adv     = (ptr_inc == {1'b0, len_ff}) ? '0 : ptr_inc[LEN_W-1:0];
   assign bit_sel     = 3'd7 - ptr_ff[2:0];
   assign cur_bit     = mem_rdata[bit_sel];
   assign value_shift = cur_bit ? {value_ff[6:0], 1'b1} :
                        (value_ff != '0) ? {value_ff[6:0], 1'b0} : value_ff;
   assign nib_sel     = 3'd7 - cnt_ff[2:0];
   always_comb begin
      wbyte          = mem_rdata;
      wbyte[bit_sel] = req_ff.data_byte[nib_sel];
   end
   assign div_dividend = (action_type'(req_ff.action) == ACT_ADVANCE) ?
                         DIV_W'({15'b0, ptr_ff})
                         + DIV_W'(req_ff.cpu_cycles >> CPB_SHIFT) :
                         DIV_W'(ptr_ff);

   // Stepper: the phase mask after this request's phase change.
   assign pb_step = req_ff.phase_on ? (pb_ff | (4'b1 << req_ff.phase))
                                    : (pb_ff & ~(4'b1 << req_ff.phase));
   assign nxt = settled_ff + 2'd1;
   assign prv = settled_ff - 2'd1;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               case (action_type'(req_payload.action)) inside
                  ACT_ADVANCE, ACT_READ, ACT_WRITE: state_in = ST_LK_MAP;
                  default:                          state_in = ST_EXEC;
               endcase
            end
         end
         ST_EXEC:   state_in = ST_LK_MAP;
         ST_LK_MAP: state_in = ST_LK_LEN;
         ST_LK_LEN: state_in = ST_LK_CHK;
         ST_LK_CHK: state_in = go_op ? ST_DIV : ST_RESP;
         ST_DIV: begin
            if (div_done) begin
               case (action_type'(req_ff.action))
                  ACT_READ:  state_in = ST_RD_ADDR;
                  ACT_WRITE: state_in = ST_WR_ADDR;
                  default:   state_in = ST_RESP;
               endcase
            end
         end
         ST_RD_ADDR: state_in = ST_RD_BIT;
         ST_RD_BIT: begin
            if (value_shift[7] || cnt_ff == CNT_W'(MAX_SYNC_BITS - 1)) begin
               state_in = ST_RESP;
            end else begin
               state_in = ST_RD_ADDR;
            end
         end
         ST_WR_ADDR: state_in = ST_WR_MOD;
         ST_WR_MOD:  state_in = (cnt_ff[2:0] == 3'd7) ? ST_RESP : ST_WR_ADDR;
         ST_RESP:    state_in = rsp_ready ? ST_IDLE : ST_RESP;
         default:    state_in = ST_IDLE;
      endcase
   end

   // Outputs: storage commands and remainder start.
   always_comb begin
      cmd           = '0;
      cmd.map_raddr = head_ff;
      cmd.len_raddr = map_rdata[TRK_W-1:0];
      cmd.mem_raddr = {trk_ff, ptr_ff[LEN_W-1:3]};
      cmd.mem_waddr = {trk_ff, ptr_ff[LEN_W-1:3]};
      cmd.mem_wdata = wbyte;
      cmd.map_waddr = req_ff.map_index;
      cmd.map_wdata = req_ff.data_byte;
      cmd.len_waddr = req_ff.track_select;
      cmd.len_wdata = req_ff.bit_length;
      div_start     = 1'b0;
      unique case (state_ff)
         ST_EXEC: begin
            case (action_type'(req_ff.action))
               ACT_MAP:    cmd.map_we = (req_ff.map_index < 8'(MAP_ENTRIES));
               ACT_LENGTH: cmd.len_we = 1'b1;
               ACT_BYTE: begin
                  cmd.mem_we    = 1'b1;
                  cmd.mem_waddr = {req_ff.track_select, req_ff.byte_address};
                  cmd.mem_wdata = req_ff.data_byte;
               end
               default: ;
            endcase
         end
         ST_LK_CHK: div_start = go_op;
         ST_WR_MOD: cmd.mem_we = 1'b1;
         default: ;
      endcase
   end

   // Datapath register updates.
   always_comb begin
      req_in     = req_ff;
      wp_in      = wp_ff;
      loaded_in  = loaded_ff;
      pb_in      = pb_ff;
      settled_in = settled_ff;
      head_in    = head_ff;
      ptr_in     = ptr_ff;
      trk_in     = trk_ff;
      trk_ok_in  = trk_ok_ff;
      len_in     = len_ff;
      ready_in   = ready_ff;
      value_in   = value_ff;
      cnt_in     = cnt_ff;
      if (cfg_wr) begin
         if (reg_index_type'(paddr[2]) == REG_DISK_LOADED) begin
            loaded_in = pwdata[0];
         end else begin
            wp_in = pwdata[0];
         end
      end
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in   = req_payload;
               value_in = '0;
            end
         end
         ST_EXEC: begin
            case (action_type'(req_ff.action))
               ACT_PHASE: begin
                  pb_in = pb_step;
                  // A release re-checks the settled phase against its neighbors.
                  if (!req_ff.phase_on && !pb_step[settled_ff]) begin
                     if (pb_step[nxt] && !pb_step[prv]) begin
                        settled_in = nxt;
                        head_in = (head_ff < HEAD_UPLIM) ? head_ff + 8'd2 : HEAD_MAX;
                     end else if (pb_step[prv] && !pb_step[nxt]) begin
                        settled_in = prv;
                        head_in = (head_ff > 8'd1) ? head_ff - 8'd2 : 8'd0;
                     end
                  end
               end
               ACT_HEAD: begin
                  head_in = (req_ff.target_quarter_track > HEAD_MAX) ?
                            HEAD_MAX : req_ff.target_quarter_track;
               end
               default: ;
            endcase
         end
         ST_LK_LEN: begin
            trk_in    = map_rdata[TRK_W-1:0];
            trk_ok_in = (map_rdata < 8'(MAX_TRACKS));
         end
         ST_LK_CHK: begin
            len_in   = len_rdata;
            ready_in = lk_ready;
            cnt_in   = '0;
         end
         ST_DIV: begin
            if (div_done) begin
               ptr_in = div_rem;
            end
         end
         ST_RD_BIT: begin
            value_in = value_shift;
            ptr_in   = ptr_adv;
            cnt_in   = cnt_ff + 1'b1;
         end
         ST_WR_MOD: begin
            ptr_in = ptr_adv;
            cnt_in = cnt_ff + 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         wp_ff      <= 1'b0;
         loaded_ff  <= 1'b0;
         pb_ff      <= '0;
         settled_ff <= '0;
         head_ff    <= '0;
         ptr_ff     <= '0;
         ready_ff   <= 1'b0;
         value_ff   <= '0;
      end else begin
         state_ff   <= state_in;
         wp_ff      <= wp_in;
         loaded_ff  <= loaded_in;
         pb_ff      <= pb_in;
         settled_ff <= settled_in;
         head_ff    <= head_in;
         ptr_ff     <= ptr_in;
         ready_ff   <= ready_in;
         value_ff   <= value_in;
      end
      req_ff    <= req_in;
      trk_ff    <= trk_in;
      trk_ok_ff <= trk_ok_in;
      len_ff    <= len_in;
      cnt_ff    <= cnt_in;
   end

endmodule
`default_nettype wire
